// ===== design/ffbta_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffbta_pkg
// Shared constants, command and status types of the boundary tag allocator.
// ----------------------------------------------------------------------------
package ffbta_pkg;

  localparam int MEM_BYTES_DEF    = 1024;
  localparam int HEADER_BYTES_DEF = 8;

  localparam int POOL_W  = 11;
  localparam int REQ_W   = 11;
  localparam int ADDR_W  = 10;
  localparam int BLK_W   = 8;
  localparam int BYTES_W = 11;
  localparam int PADDR_W = 3;

  localparam int POOL_MIN   = 64;
  localparam int POOL_RESET = 1024;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic REG_POOL_SIZE = 1'b0;

  localparam logic [1:0] RD_NONE = 2'd0;
  localparam logic [1:0] RD_OFF  = 2'd1;
  localparam logic [1:0] RD_P    = 2'd2;
  localparam logic [1:0] RD_END  = 2'd3;

  localparam logic [3:0] WR_NONE       = 4'd0;
  localparam logic [3:0] WR_INIT       = 4'd1;
  localparam logic [3:0] WR_SPLIT_NEW  = 4'd2;
  localparam logic [3:0] WR_END_PREV_N = 4'd3;
  localparam logic [3:0] WR_CUR_ALLOC  = 4'd4;
  localparam logic [3:0] WR_TAKE       = 4'd5;
  localparam logic [3:0] WR_CUR_FREE   = 4'd6;
  localparam logic [3:0] WR_NN_PREV_P  = 4'd7;
  localparam logic [3:0] WR_NN_PREV_C  = 4'd8;
  localparam logic [3:0] WR_END_PREV_P = 4'd9;
  localparam logic [3:0] WR_P_SIZE3    = 4'd10;
  localparam logic [3:0] WR_P_SIZE2    = 4'd11;
  localparam logic [3:0] WR_C_SIZE2    = 4'd12;

  localparam logic [1:0] RES_NONE     = 2'd0;
  localparam logic [1:0] RES_FAIL     = 2'd1;
  localparam logic [1:0] RES_ALLOC_OK = 2'd2;
  localparam logic [1:0] RES_FREE_OK  = 2'd3;

  typedef struct packed {
    logic       start;
    logic       walk_init;
    logic       step;
    logic       acc;
    logic       hit_save;
    logic       clr_pe;
    logic       save_p;
    logic       save_e;
    logic [1:0] rd;
    logic [3:0] wr;
    logic [1:0] res;
    logic       load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic op;
    logic off_end;
    logic addr_low;
    logic fit;
    logic split;
    logic ent_free;
    logic is_c;
    logic past_c;
    logic has_prev;
    logic a_end_lt;
    logic f_end_lt;
    logic nn_lt;
    logic pf;
    logic ef;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== design/first_fit_boundary_tag_allocator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_boundary_tag_allocator
// Requests are handled one at a time: a chain walk over the headers, any split
// or coalescing writes, then a usage walk over every chunk before out_valid.
// The next request is taken once the result is registered. After reset the
// initial free chunk is written before the first request is taken.
// Writing pool_size reinitializes the pool at once.
// ----------------------------------------------------------------------------
// APB register port, request and result channels around the allocator core.
// ----------------------------------------------------------------------------
module first_fit_boundary_tag_allocator #(
  parameter int MEM_BYTES    = ffbta_pkg::MEM_BYTES_DEF,
  parameter int HEADER_BYTES = ffbta_pkg::HEADER_BYTES_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire  [ffbta_pkg::PADDR_W-1:0]        paddr,
  input  wire  [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire                                  in_op,
  input  wire  [ffbta_pkg::REQ_W-1:0]          in_request_size,
  input  wire  [ffbta_pkg::ADDR_W-1:0]         in_address,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic                                 out_ok,
  output logic [ffbta_pkg::ADDR_W-1:0]         out_alloc_address,
  output logic [ffbta_pkg::BLK_W-1:0]          out_used_blocks,
  output logic [ffbta_pkg::BYTES_W-1:0]        out_used_bytes,
  output logic [ffbta_pkg::BYTES_W-1:0]        out_largest_free
);

  localparam int SW = $clog2(MEM_BYTES) + 1;

  ffbta_pkg::dp_cmd_t cmd;
  ffbta_pkg::dp_sts_t sts;
  logic               cfg_we;
  logic [SW-1:0]      pool_size;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == ffbta_pkg::REG_POOL_SIZE);
  assign prdata = (paddr[2] == ffbta_pkg::REG_POOL_SIZE) ? 32'(pool_size) : 32'd0;

  ffbta_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ffbta_dpath #(
    .MEM_BYTES    (MEM_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .SW           (SW)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_op             (in_op),
    .in_request_size   (in_request_size),
    .in_address        (in_address),
    .cfg_we            (cfg_we),
    .cfg_wdata         (pwdata[ffbta_pkg::POOL_W-1:0]),
    .pool_size         (pool_size),
    .out_ok            (out_ok),
    .out_alloc_address (out_alloc_address),
    .out_used_blocks   (out_used_blocks),
    .out_used_bytes    (out_used_bytes),
    .out_largest_free  (out_largest_free)
  );

endmodule
`default_nettype wire

// ===== design/ffbta_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffbta_dpath
// Header memory, chain pointer, merge operands, usage counters and result
// registers of the allocator.
// ----------------------------------------------------------------------------
module ffbta_dpath #(
  parameter int MEM_BYTES    = ffbta_pkg::MEM_BYTES_DEF,
  parameter int HEADER_BYTES = ffbta_pkg::HEADER_BYTES_DEF,
  parameter int SW           = $clog2(MEM_BYTES) + 1
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  ffbta_pkg::dp_cmd_t                cmd,
  output ffbta_pkg::dp_sts_t                sts,
  input  wire                               in_op,
  input  wire [ffbta_pkg::REQ_W-1:0]        in_request_size,
  input  wire [ffbta_pkg::ADDR_W-1:0]       in_address,
  input  wire                               cfg_we,
  input  wire [ffbta_pkg::POOL_W-1:0]       cfg_wdata,
  output logic [SW-1:0]                     pool_size,
  output logic                              out_ok,
  output logic [ffbta_pkg::ADDR_W-1:0]      out_alloc_address,
  output logic [ffbta_pkg::BLK_W-1:0]       out_used_blocks,
  output logic [ffbta_pkg::BYTES_W-1:0]     out_used_bytes,
  output logic [ffbta_pkg::BYTES_W-1:0]     out_largest_free
);

  localparam int AW  = $clog2(MEM_BYTES);
  localparam int XW  = ((SW > ffbta_pkg::REQ_W) ? SW : ffbta_pkg::REQ_W) + 1;
  localparam int POOL_RST = (ffbta_pkg::POOL_RESET > MEM_BYTES) ? MEM_BYTES
                                                                : ffbta_pkg::POOL_RESET;

  localparam logic [XW-1:0] HB   = XW'(HEADER_BYTES);
  localparam logic [XW-1:0] PMIN = XW'(ffbta_pkg::POOL_MIN);
  localparam logic [XW-1:0] PMAX = XW'(MEM_BYTES);

  logic            free_mem [MEM_BYTES];
  logic [SW-1:0]   size_mem [MEM_BYTES];
  logic [AW-1:0]   prev_mem [MEM_BYTES];

  logic [SW-1:0]   pool_r, pool_nxt;
  logic            op_r;
  logic [ffbta_pkg::REQ_W-1:0]  req_r;
  logic [ffbta_pkg::ADDR_W-1:0] addr_r;
  logic [SW-1:0]   off_r;
  logic            ent_free_r;
  logic [SW-1:0]   ent_size_r;
  logic [AW-1:0]   ent_prev_r;
  logic [SW-1:0]   cur_size_r;
  logic [AW-1:0]   cur_prev_r;
  logic            pf_r, ef_r;
  logic [SW-1:0]   ps_r, es_r;
  logic [SW-1:0]   blocks_r, bytes_r, big_r;
  logic            ok_r;
  logic [ffbta_pkg::ADDR_W-1:0] aaddr_r;

  logic [XW-1:0]   ds, c_w, n_w, a_end, f_end, nn, cfg_v;
  logic            rd_en;
  logic [AW-1:0]   raddr, waddr;
  logic            we_f, we_s, we_p, wd_f;
  logic [SW-1:0]   wd_s;
  logic [AW-1:0]   wd_p;

  assign ds    = XW'(ent_size_r) - HB;
  assign c_w   = XW'(addr_r) - HB;
  assign n_w   = XW'(off_r) + HB + XW'(req_r);
  assign a_end = XW'(off_r) + XW'(ent_size_r);
  assign f_end = XW'(off_r) + XW'(cur_size_r);
  assign nn    = f_end + XW'(es_r);
  assign cfg_v = (XW'(cfg_wdata) < PMIN) ? PMIN :
                 (XW'(cfg_wdata) > PMAX) ? PMAX : XW'(cfg_wdata);

  assign pool_size = pool_r;

  always_comb begin
    sts.op       = op_r;
    sts.off_end  = off_r >= pool_r;
    sts.addr_low = XW'(addr_r) < HB;
    sts.fit      = ent_free_r && (ds >= XW'(req_r));
    sts.split    = (ds - XW'(req_r)) >= HB;
    sts.ent_free = ent_free_r;
    sts.is_c     = XW'(off_r) == c_w;
    sts.past_c   = XW'(off_r) > c_w;
    sts.has_prev = off_r != '0;
    sts.a_end_lt = a_end < XW'(pool_r);
    sts.f_end_lt = f_end < XW'(pool_r);
    sts.nn_lt    = nn < XW'(pool_r);
    sts.pf       = pf_r;
    sts.ef       = ef_r;
  end

  always_comb begin
    rd_en = 1'b1;
    raddr = off_r[AW-1:0];
    case (cmd.rd)
      ffbta_pkg::RD_OFF: raddr = off_r[AW-1:0];
      ffbta_pkg::RD_P:   raddr = cur_prev_r;
      ffbta_pkg::RD_END: raddr = f_end[AW-1:0];
      default:           rd_en = 1'b0;
    endcase
  end

  always_comb begin
    waddr = off_r[AW-1:0];
    we_f  = 1'b0;
    we_s  = 1'b0;
    we_p  = 1'b0;
    wd_f  = 1'b0;
    wd_s  = ent_size_r;
    wd_p  = off_r[AW-1:0];
    if (cfg_we) begin
      waddr = '0;
      {we_f, we_s, we_p} = 3'b111;
      wd_f  = 1'b1;
      wd_s  = SW'(cfg_v);
      wd_p  = '0;
    end else begin
      case (cmd.wr)
        ffbta_pkg::WR_INIT: begin
          waddr = '0;
          {we_f, we_s, we_p} = 3'b111;
          wd_f  = 1'b1;
          wd_s  = pool_r;
          wd_p  = '0;
        end
        ffbta_pkg::WR_SPLIT_NEW: begin
          waddr = n_w[AW-1:0];
          {we_f, we_s, we_p} = 3'b111;
          wd_f  = 1'b1;
          wd_s  = SW'(ds - XW'(req_r));
          wd_p  = off_r[AW-1:0];
        end
        ffbta_pkg::WR_END_PREV_N: begin
          waddr = a_end[AW-1:0];
          we_p  = 1'b1;
          wd_p  = n_w[AW-1:0];
        end
        ffbta_pkg::WR_CUR_ALLOC: begin
          we_f  = 1'b1;
          we_s  = 1'b1;
          wd_s  = SW'(HB + XW'(req_r));
        end
        ffbta_pkg::WR_TAKE: begin
          we_f  = 1'b1;
        end
        ffbta_pkg::WR_CUR_FREE: begin
          we_f  = 1'b1;
          wd_f  = 1'b1;
        end
        ffbta_pkg::WR_NN_PREV_P: begin
          waddr = nn[AW-1:0];
          we_p  = 1'b1;
          wd_p  = cur_prev_r;
        end
        ffbta_pkg::WR_NN_PREV_C: begin
          waddr = nn[AW-1:0];
          we_p  = 1'b1;
        end
        ffbta_pkg::WR_END_PREV_P: begin
          waddr = f_end[AW-1:0];
          we_p  = 1'b1;
          wd_p  = cur_prev_r;
        end
        ffbta_pkg::WR_P_SIZE3: begin
          waddr = cur_prev_r;
          we_s  = 1'b1;
          wd_s  = SW'(XW'(ps_r) + XW'(cur_size_r) + XW'(es_r));
        end
        ffbta_pkg::WR_P_SIZE2: begin
          waddr = cur_prev_r;
          we_s  = 1'b1;
          wd_s  = SW'(XW'(ps_r) + XW'(cur_size_r));
        end
        ffbta_pkg::WR_C_SIZE2: begin
          we_s  = 1'b1;
          wd_s  = SW'(XW'(cur_size_r) + XW'(es_r));
        end
        default: begin
          we_f  = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we_f) free_mem[waddr] <= wd_f;
    if (we_s) size_mem[waddr] <= wd_s;
    if (we_p) prev_mem[waddr] <= wd_p;
    if (rd_en) begin
      ent_free_r <= free_mem[raddr];
      ent_size_r <= size_mem[raddr];
      ent_prev_r <= prev_mem[raddr];
    end
  end

  always_comb begin
    pool_nxt = pool_r;
    if (cfg_we) pool_nxt = SW'(cfg_v);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r <= SW'(POOL_RST);
    end else begin
      pool_r <= pool_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r   <= in_op;
      req_r  <= in_request_size;
      addr_r <= in_address;
    end
    if (cmd.walk_init) begin
      off_r    <= '0;
      blocks_r <= '0;
      bytes_r  <= '0;
      big_r    <= '0;
    end else if (cmd.step) begin
      off_r <= SW'(a_end);
    end
    if (cmd.acc) begin
      if (ent_free_r) begin
        if (SW'(ds) > big_r) big_r <= SW'(ds);
      end else begin
        blocks_r <= blocks_r + SW'(1);
        bytes_r  <= bytes_r + SW'(ds);
      end
    end
    if (cmd.hit_save) begin
      cur_size_r <= ent_size_r;
      cur_prev_r <= ent_prev_r;
    end
    if (cmd.clr_pe) begin
      pf_r <= 1'b0;
      ef_r <= 1'b0;
    end
    if (cmd.save_p) begin
      pf_r <= ent_free_r;
      ps_r <= ent_size_r;
    end
    if (cmd.save_e) begin
      ef_r <= ent_free_r;
      es_r <= ent_size_r;
    end
    case (cmd.res)
      ffbta_pkg::RES_FAIL: begin
        ok_r    <= 1'b0;
        aaddr_r <= '0;
      end
      ffbta_pkg::RES_ALLOC_OK: begin
        ok_r    <= 1'b1;
        aaddr_r <= ffbta_pkg::ADDR_W'(XW'(off_r) + HB);
      end
      ffbta_pkg::RES_FREE_OK: begin
        ok_r    <= 1'b1;
        aaddr_r <= '0;
      end
      default: begin
        ok_r    <= ok_r;
      end
    endcase
    if (cmd.load_out) begin
      out_ok            <= ok_r;
      out_alloc_address <= aaddr_r;
      out_used_blocks   <= ffbta_pkg::BLK_W'(blocks_r);
      out_used_bytes    <= ffbta_pkg::BYTES_W'(bytes_r);
      out_largest_free  <= ffbta_pkg::BYTES_W'(big_r);
    end
  end

endmodule
`default_nettype wire

// ===== design/ffbta_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffbta_ctrl
// Sequencer for chain walk, split, coalescing, usage walk and result beat.
// ----------------------------------------------------------------------------
module ffbta_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire                 out_ready,
  input  ffbta_pkg::dp_sts_t  sts,
  output ffbta_pkg::dp_cmd_t  cmd
);

  localparam logic [4:0] ST_INIT = 5'd0;
  localparam logic [4:0] ST_IDLE = 5'd1;
  localparam logic [4:0] ST_WRD  = 5'd2;
  localparam logic [4:0] ST_WCHK = 5'd3;
  localparam logic [4:0] ST_SPL1 = 5'd4;
  localparam logic [4:0] ST_SPL2 = 5'd5;
  localparam logic [4:0] ST_SPL3 = 5'd6;
  localparam logic [4:0] ST_FP   = 5'd7;
  localparam logic [4:0] ST_FPS  = 5'd8;
  localparam logic [4:0] ST_FE   = 5'd9;
  localparam logic [4:0] ST_FES  = 5'd10;
  localparam logic [4:0] ST_M1   = 5'd11;
  localparam logic [4:0] ST_M2   = 5'd12;
  localparam logic [4:0] ST_SUM0 = 5'd13;
  localparam logic [4:0] ST_SRD  = 5'd14;
  localparam logic [4:0] ST_SCHK = 5'd15;
  localparam logic [4:0] ST_DONE = 5'd16;

  logic [4:0] state_r, state_nxt;
  logic       ov_r, ov_nxt;

  assign in_ready  = state_r == ST_IDLE;
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_INIT: begin
        cmd.wr    = ffbta_pkg::WR_INIT;
        state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start     = 1'b1;
          cmd.walk_init = 1'b1;
          state_nxt     = ST_WRD;
        end
      end
      ST_WRD: begin
        if (sts.off_end || (sts.op == ffbta_pkg::OP_FREE && sts.addr_low)) begin
          cmd.res   = ffbta_pkg::RES_FAIL;
          state_nxt = ST_SUM0;
        end else begin
          cmd.rd    = ffbta_pkg::RD_OFF;
          state_nxt = ST_WCHK;
        end
      end
      ST_WCHK: begin
        if (sts.op == ffbta_pkg::OP_ALLOC) begin
          if (sts.fit) begin
            if (sts.split) begin
              state_nxt = ST_SPL1;
            end else begin
              cmd.wr    = ffbta_pkg::WR_TAKE;
              cmd.res   = ffbta_pkg::RES_ALLOC_OK;
              state_nxt = ST_SUM0;
            end
          end else begin
            cmd.step  = 1'b1;
            state_nxt = ST_WRD;
          end
        end else if (sts.is_c) begin
          if (sts.ent_free) begin
            cmd.res   = ffbta_pkg::RES_FAIL;
            state_nxt = ST_SUM0;
          end else begin
            cmd.hit_save = 1'b1;
            cmd.clr_pe   = 1'b1;
            cmd.wr       = ffbta_pkg::WR_CUR_FREE;
            state_nxt    = ST_FP;
          end
        end else if (sts.past_c) begin
          cmd.res   = ffbta_pkg::RES_FAIL;
          state_nxt = ST_SUM0;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = ST_WRD;
        end
      end
      ST_SPL1: begin
        cmd.wr    = ffbta_pkg::WR_SPLIT_NEW;
        state_nxt = ST_SPL2;
      end
      ST_SPL2: begin
        if (sts.a_end_lt) cmd.wr = ffbta_pkg::WR_END_PREV_N;
        state_nxt = ST_SPL3;
      end
      ST_SPL3: begin
        cmd.wr    = ffbta_pkg::WR_CUR_ALLOC;
        cmd.res   = ffbta_pkg::RES_ALLOC_OK;
        state_nxt = ST_SUM0;
      end
      ST_FP: begin
        if (sts.has_prev) begin
          cmd.rd    = ffbta_pkg::RD_P;
          state_nxt = ST_FPS;
        end else begin
          state_nxt = ST_FE;
        end
      end
      ST_FPS: begin
        cmd.save_p = 1'b1;
        state_nxt  = ST_FE;
      end
      ST_FE: begin
        if (sts.f_end_lt) begin
          cmd.rd    = ffbta_pkg::RD_END;
          state_nxt = ST_FES;
        end else begin
          state_nxt = ST_M1;
        end
      end
      ST_FES: begin
        cmd.save_e = 1'b1;
        state_nxt  = ST_M1;
      end
      ST_M1: begin
        if (sts.pf && sts.ef) begin
          if (sts.nn_lt) cmd.wr = ffbta_pkg::WR_NN_PREV_P;
        end else if (sts.pf) begin
          if (sts.f_end_lt) cmd.wr = ffbta_pkg::WR_END_PREV_P;
        end else if (sts.ef) begin
          if (sts.nn_lt) cmd.wr = ffbta_pkg::WR_NN_PREV_C;
        end
        state_nxt = ST_M2;
      end
      ST_M2: begin
        if (sts.pf && sts.ef) cmd.wr = ffbta_pkg::WR_P_SIZE3;
        else if (sts.pf)      cmd.wr = ffbta_pkg::WR_P_SIZE2;
        else if (sts.ef)      cmd.wr = ffbta_pkg::WR_C_SIZE2;
        cmd.res   = ffbta_pkg::RES_FREE_OK;
        state_nxt = ST_SUM0;
      end
      ST_SUM0: begin
        cmd.walk_init = 1'b1;
        state_nxt     = ST_SRD;
      end
      ST_SRD: begin
        if (sts.off_end) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.rd    = ffbta_pkg::RD_OFF;
          state_nxt = ST_SCHK;
        end
      end
      ST_SCHK: begin
        cmd.acc   = 1'b1;
        cmd.step  = 1'b1;
        state_nxt = ST_SRD;
      end
      ST_DONE: begin
        if (!ov_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (cmd.load_out)          ov_nxt = 1'b1;
    else if (ov_r && out_ready) ov_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Allocator bench
// Drives allocate and free requests into the first-fit allocator with random
// gaps and back-pressure, predicts results from a software model of the header
// chain (fixed ones for some directed requests), rewrites the pool size between phases.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int HDR = ffbta_pkg::HEADER_BYTES_DEF;
  localparam int MEMB = ffbta_pkg::MEM_BYTES_DEF;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic                             ok;
    logic [ffbta_pkg::ADDR_W-1:0]     addr;
    logic [ffbta_pkg::BLK_W-1:0]      blocks;
    logic [ffbta_pkg::BYTES_W-1:0]    bytes;
    logic [ffbta_pkg::BYTES_W-1:0]    largest;
  } alloc_res_t;

  typedef struct {
    logic                         op;
    logic [ffbta_pkg::REQ_W-1:0]  size;
    logic [ffbta_pkg::ADDR_W-1:0] addr;
    logic                         has_exp;
    alloc_res_t                   exp;
  } req_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ffbta_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_op = 1'b0;
  logic [ffbta_pkg::REQ_W-1:0] in_request_size = '0;
  logic [ffbta_pkg::ADDR_W-1:0] in_address = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_ok;
  logic [ffbta_pkg::ADDR_W-1:0] out_alloc_address;
  logic [ffbta_pkg::BLK_W-1:0] out_used_blocks;
  logic [ffbta_pkg::BYTES_W-1:0] out_used_bytes;
  logic [ffbta_pkg::BYTES_W-1:0] out_largest_free;

  first_fit_boundary_tag_allocator u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Model of the header chain.
  bit          hdr_free [MEMB];
  int unsigned hdr_size [MEMB];
  int unsigned hdr_prev [MEMB];
  int unsigned pool_bytes;

  alloc_res_t  pending_results[$];
  int unsigned live_addrs[$];
  int          failures = 0;
  int          idle_cycles = 0;
  bit          rx_hold = 1'b0;
  bit          stim_done = 1'b0;

  function automatic void pool_init(int unsigned v);
    if (v < ffbta_pkg::POOL_MIN) v = ffbta_pkg::POOL_MIN;
    if (v > MEMB) v = MEMB;
    pool_bytes = v;
    for (int k = 0; k < MEMB; k++) begin
      hdr_free[k] = 1'b0;
      hdr_size[k] = 0;
      hdr_prev[k] = 0;
    end
    hdr_free[0] = 1'b1;
    hdr_size[0] = v;
    live_addrs.delete();
  endfunction

  function automatic int unsigned chunk_next(int unsigned o);
    if (hdr_size[o] < HDR) return pool_bytes;
    return o + hdr_size[o];
  endfunction

  function automatic alloc_res_t pool_apply(logic op, int unsigned req, int unsigned a);
    alloc_res_t r;
    int unsigned o, steps, ds, n, e, c, p, nn, blocks, bytes, big;
    bit found;
    r = '0;
    o = 0;
    steps = 0;
    if (op == ffbta_pkg::OP_ALLOC) begin
      while (o < pool_bytes && steps < MEMB) begin
        ds = hdr_size[o] - HDR;
        if (hdr_free[o] && ds >= req) begin
          if (ds - req >= HDR) begin
            n = o + HDR + req;
            e = o + hdr_size[o];
            hdr_free[n] = 1'b1;
            hdr_size[n] = e - n;
            hdr_prev[n] = o;
            if (e < pool_bytes) hdr_prev[e] = n;
            hdr_size[o] = n - o;
          end
          hdr_free[o] = 1'b0;
          r.ok = 1'b1;
          r.addr = ffbta_pkg::ADDR_W'(o + HDR);
          live_addrs.push_back(o + HDR);
          break;
        end
        o = chunk_next(o);
        steps++;
      end
    end else if (a >= HDR) begin
      c = a - HDR;
      found = 1'b0;
      while (o < pool_bytes && steps < MEMB) begin
        if (o == c) begin
          found = 1'b1;
          break;
        end
        if (o > c) break;
        o = chunk_next(o);
        steps++;
      end
      if (found && !hdr_free[c]) begin
        r.ok = 1'b1;
        hdr_free[c] = 1'b1;
        e = c + hdr_size[c];
        p = hdr_prev[c];
        if (p >= MEMB) p = 0;
        if (c != 0 && e < pool_bytes && hdr_free[p] && hdr_free[e]) begin
          nn = e + hdr_size[e];
          if (nn < pool_bytes) hdr_prev[nn] = p;
          hdr_size[p] += hdr_size[c] + hdr_size[e];
        end else if (c != 0 && hdr_free[p]) begin
          if (e < pool_bytes) hdr_prev[e] = p;
          hdr_size[p] += hdr_size[c];
        end else if (e < pool_bytes && hdr_free[e]) begin
          nn = e + hdr_size[e];
          if (nn < pool_bytes) hdr_prev[nn] = c;
          hdr_size[c] += hdr_size[e];
        end
        foreach (live_addrs[k]) if (live_addrs[k] == a) begin
          live_addrs.delete(k);
          break;
        end
      end
    end
    o = 0;
    steps = 0;
    blocks = 0;
    bytes = 0;
    big = 0;
    while (o < pool_bytes && steps < MEMB) begin
      ds = hdr_size[o] - HDR;
      if (hdr_free[o]) begin
        if (ds > big) big = ds;
      end else begin
        blocks++;
        bytes += ds;
      end
      o = chunk_next(o);
      steps++;
    end
    r.blocks = ffbta_pkg::BLK_W'(blocks);
    r.bytes = ffbta_pkg::BYTES_W'(bytes);
    r.largest = ffbta_pkg::BYTES_W'(big);
    return r;
  endfunction

  task automatic write_pool_size(int unsigned v);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= ffbta_pkg::PADDR_W'(4 * ffbta_pkg::REG_POOL_SIZE);
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    pool_init(v & 32'h7FF);
  endtask

  task automatic send_request(logic op, int unsigned sz, int unsigned a, bit gaps);
    @(negedge clk);
    if (gaps && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3))
        @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_request_size <= ffbta_pkg::REQ_W'(sz);
    in_address <= ffbta_pkg::ADDR_W'(a);
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(pool_apply(op, sz, a));
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (3000) @(negedge clk);
  endtask

  task automatic random_phase(int count);
    int unsigned sz, a;
    for (int k = 0; k < count; k++) begin
      if (live_addrs.size() != 0 && $urandom_range(0, 99) < 45) begin
        a = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
        if ($urandom_range(0, 19) == 0) a = $urandom_range(0, 1023);
        send_request(ffbta_pkg::OP_FREE, $urandom_range(0, 2047), a, 1'b1);
      end else begin
        case ($urandom_range(0, 9))
          0: sz = $urandom_range(0, 2047);
          1: sz = $urandom_range(100, 1024);
          default: sz = $urandom_range(0, 64);
        endcase
        send_request(ffbta_pkg::OP_ALLOC, sz, $urandom_range(0, 1023), 1'b1);
      end
    end
  endtask

  // Receiver: random stalls, with one long hold-off requested by the sender side.
  always @(negedge clk) begin
    if (rx_hold) out_ready <= 1'b0;
    else if ($urandom_range(0, 3) == 0) out_ready <= 1'b0;
    else out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    alloc_res_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_ok, out_alloc_address, out_used_blocks, out_used_bytes, out_largest_free};
      if (pending_results.size() == 0) begin
        $error("unexpected result beat %h", got);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (got.ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, got.ok);
          failures++;
        end
        if (got.addr !== want.addr) begin
          $error("alloc_address: expected %0d, got %0d", want.addr, got.addr);
          failures++;
        end
        if (got.blocks !== want.blocks) begin
          $error("used_blocks: expected %0d, got %0d", want.blocks, got.blocks);
          failures++;
        end
        if (got.bytes !== want.bytes) begin
          $error("used_bytes: expected %0d, got %0d", want.bytes, got.bytes);
          failures++;
        end
        if (got.largest !== want.largest) begin
          $error("largest_free: expected %0d, got %0d", want.largest, got.largest);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel || stim_done || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG && !rx_hold) begin
      $display("tb_top failed");
      $finish;
    end
  end

  req_row_t directed[$];

  function automatic req_row_t row(logic op, int unsigned sz, int unsigned a, bit he,
                                   alloc_res_t e);
    req_row_t r;
    r.op = op;
    r.size = ffbta_pkg::REQ_W'(sz);
    r.addr = ffbta_pkg::ADDR_W'(a);
    r.has_exp = he;
    r.exp = e;
    return r;
  endfunction

  initial begin
    alloc_res_t none;
    none = '0;
    pool_init(ffbta_pkg::POOL_RESET);
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    repeat (4) @(negedge clk);

    directed.push_back(row(ffbta_pkg::OP_ALLOC, 2047, 0, 1'b1,
                           '{1'b0, 10'd0, 8'd0, 11'd0, 11'd1016}));
    directed.push_back(row(ffbta_pkg::OP_FREE, 0, 0, 1'b1,
                           '{1'b0, 10'd0, 8'd0, 11'd0, 11'd1016}));
    directed.push_back(row(ffbta_pkg::OP_FREE, 0, 7, 1'b1,
                           '{1'b0, 10'd0, 8'd0, 11'd0, 11'd1016}));
    directed.push_back(row(ffbta_pkg::OP_FREE, 0, 8, 1'b1,
                           '{1'b0, 10'd0, 8'd0, 11'd0, 11'd1016}));
    directed.push_back(row(ffbta_pkg::OP_ALLOC, 0, 1023, 1'b1,
                           '{1'b1, 10'd8, 8'd1, 11'd0, 11'd1008}));
    directed.push_back(row(ffbta_pkg::OP_ALLOC, 16, 0, 1'b1,
                           '{1'b1, 10'd16, 8'd2, 11'd16, 11'd984}));
    directed.push_back(row(ffbta_pkg::OP_ALLOC, 32, 0, 1'b0, none));
    directed.push_back(row(ffbta_pkg::OP_ALLOC, 8, 0, 1'b0, none));
    directed.push_back(row(ffbta_pkg::OP_FREE, 0, 17, 1'b0, none));
    directed.push_back(row(ffbta_pkg::OP_FREE, 0, 16, 1'b0, none));
    directed.push_back(row(ffbta_pkg::OP_FREE, 0, 16, 1'b0, none));
    directed.push_back(row(ffbta_pkg::OP_FREE, 0, 8, 1'b0, none));
    directed.push_back(row(ffbta_pkg::OP_FREE, 0, 72, 1'b0, none));
    directed.push_back(row(ffbta_pkg::OP_FREE, 0, 112, 1'b0, none));
    directed.push_back(row(ffbta_pkg::OP_ALLOC, 1016, 0, 1'b0, none));
    directed.push_back(row(ffbta_pkg::OP_FREE, 0, 8, 1'b0, none));
    directed.push_back(row(ffbta_pkg::OP_ALLOC, 1009, 0, 1'b0, none));
    directed.push_back(row(ffbta_pkg::OP_ALLOC, 1024, 0, 1'b0, none));
    directed.push_back(row(ffbta_pkg::OP_ALLOC, 1017, 0, 1'b0, none));
    directed.push_back(row(ffbta_pkg::OP_FREE, 0, 1023, 1'b0, none));
    directed.push_back(row(ffbta_pkg::OP_FREE, 0, 1016, 1'b0, none));

    foreach (directed[k]) begin
      send_request(directed[k].op, directed[k].size, directed[k].addr, 1'b0);
      if (directed[k].has_exp) pending_results[$] = directed[k].exp;
    end
    drain_results();

    // Long receiver hold-off while requests keep coming.
    fork
      begin
        rx_hold = 1'b1;
        repeat (600) @(negedge clk);
        rx_hold = 1'b0;
      end
      random_phase(20);
    join
    drain_results();

    random_phase(500);
    drain_results();
    write_pool_size(64);
    random_phase(200);
    drain_results();
    write_pool_size(2047);
    random_phase(250);
    drain_results();
    write_pool_size($urandom_range(65, 1023));
    random_phase(250);
    drain_results();
    write_pool_size(0);
    random_phase(100);
    drain_results();
    write_pool_size(1024);
    random_phase(60);
    drain_results();

    stim_done = 1'b1;
    if (failures == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
design/ffbta_pkg.sv
design/ffbta_dpath.sv
design/ffbta_ctrl.sv
design/first_fit_boundary_tag_allocator.sv
bench/tb_top.sv
